// File: rtl/core/look_at_camera_basis_top_macros.svh
// Assertion macros for the look-at camera basis block.
`ifndef LOOK_AT_CAMERA_BASIS_TOP_MACROS_SVH
`define LOOK_AT_CAMERA_BASIS_TOP_MACROS_SVH
`ifndef SYNTH
`define LACB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("lacb assertion failed");
`define LACB_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("lacb assertion failed");
`else
`define LACB_ASSERT(lbl, prop)
`define LACB_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: rtl/core/lacb_pkg.sv
// Shared constants for the look-at camera basis block.
`default_nettype none
package lacb_pkg;
	localparam int UNIT_FRAC_BITS = 14;
	localparam int COORD_W        = 32;
	localparam int UNIT_OUT_W     = 16;
	localparam int MAG_W          = 30;
	localparam int SUM_W          = 2 * MAG_W + 2;
	localparam int ROOT_W         = MAG_W + 1;
endpackage
`default_nettype wire

// File: rtl/core/lacb_norm.sv
// Pipelined vector normalizer: scale, sum of squares, bitwise root, long division.
`default_nettype none
module lacb_norm #(
	parameter int VW  = 33,
	parameter int UFB = lacb_pkg::UNIT_FRAC_BITS,
	parameter int SW  = 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_valid,
	input  wire logic [2:0][VW-1:0]      vec,
	input  wire logic [SW-1:0]           side_in,
	output logic                         out_valid,
	output logic [2:0][UFB+1:0]          unit,
	output logic                         zero,
	output logic [SW-1:0]                side_out
);
	localparam int UW  = UFB + 2;
	localparam int TW  = SW + 4;
	localparam int BW  = $clog2(VW + 1);
	localparam int MW  = lacb_pkg::MAG_W;
	localparam int SQW = lacb_pkg::SUM_W;
	localparam int RW  = lacb_pkg::ROOT_W;
	localparam int QW  = UFB + 1;
	localparam int NW  = RW + UFB;

	// tag = {side, neg[2:0], zero}
	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [2:0][VW-1:0]   mag_s1, mag_s2;
	logic [TW-1:0]        tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic [BW-1:0]        bits_s2;
	logic [2:0][MW-1:0]   m_s3, m_s4, m_s5;
	logic [2:0][2*MW-1:0] sq_s4;
	logic [SQW-1:0]       sum_s5;
	logic [VW-1:0]        or_mag;
	logic [BW-1:0]        bits_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign or_mag = mag_s1[0] | mag_s1[1] | mag_s1[2];

	always_comb begin
		bits_c = '0;
		for (int i = 0; i < VW; i++) begin
			if (or_mag[i]) bits_c = BW'(i + 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				mag_s1[c] <= vec[c][VW-1] ? VW'(-vec[c]) : vec[c];
				m_s3[c]   <= MW'({mag_s2[c], {MW{1'b0}}} >> bits_s2);
				sq_s4[c]  <= m_s3[c] * m_s3[c];
			end
			tag_s1  <= {side_in, vec[2][VW-1], vec[1][VW-1], vec[0][VW-1], (vec == '0)};
			mag_s2  <= mag_s1;
			bits_s2 <= bits_c;
			tag_s2  <= tag_s1;
			tag_s3  <= tag_s2;
			m_s4    <= m_s3;
			tag_s4  <= tag_s3;
			sum_s5  <= SQW'(sq_s4[0]) + SQW'(sq_s4[1]) + SQW'(sq_s4[2]);
			m_s5    <= m_s4;
			tag_s5  <= tag_s4;
		end
	end

	// square root, one result bit per stage
	logic [RW-1:0]      rt_root_s [RW+1];
	logic [SQW-1:0]     rt_rem_s  [RW+1];
	logic [2:0][MW-1:0] rt_m_s    [RW+1];
	logic [TW-1:0]      rt_tag_s  [RW+1];
	logic               rt_v_s    [RW+1];

	assign rt_root_s[0] = '0;
	assign rt_rem_s[0]  = sum_s5;
	assign rt_m_s[0]    = m_s5;
	assign rt_tag_s[0]  = tag_s5;
	assign rt_v_s[0]    = v_s5;

	for (genvar j = 1; j <= RW; j++) begin : g_sqrt
		localparam int I = RW - j;
		logic [SQW:0] trial;
		assign trial = ((SQW+1)'(rt_root_s[j-1]) << (I + 1)) + ((SQW+1)'(1) << (2 * I));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_v_s[j] <= 1'b0;
			else if (en) rt_v_s[j] <= rt_v_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if ((SQW+1)'(rt_rem_s[j-1]) >= trial) begin
					rt_rem_s[j]  <= rt_rem_s[j-1] - trial[SQW-1:0];
					rt_root_s[j] <= rt_root_s[j-1] | (RW'(1) << I);
				end else begin
					rt_rem_s[j]  <= rt_rem_s[j-1];
					rt_root_s[j] <= rt_root_s[j-1];
				end
				rt_m_s[j]   <= rt_m_s[j-1];
				rt_tag_s[j] <= rt_tag_s[j-1];
			end
		end
	end

	// rounded division, one quotient bit per stage
	logic [2:0][NW-1:0] dv_rem_s [QW+1];
	logic [2:0][QW-1:0] dv_q_s   [QW+1];
	logic [RW-1:0]      dv_len_s [QW+1];
	logic [TW-1:0]      dv_tag_s [QW+1];
	logic               dv_v_s   [QW+1];

	assign dv_q_s[0] = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_s[0] <= 1'b0;
		else if (en) dv_v_s[0] <= rt_v_s[RW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				dv_rem_s[0][c] <= (NW'(rt_m_s[RW][c]) << UFB) + NW'(rt_root_s[RW] >> 1);
			end
			dv_len_s[0] <= rt_root_s[RW];
			dv_tag_s[0] <= rt_tag_s[RW];
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_div
		localparam int K = QW - j;
		logic [NW-1:0] dsr;
		assign dsr = NW'(dv_len_s[j-1]) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[j] <= 1'b0;
			else if (en) dv_v_s[j] <= dv_v_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int c = 0; c < 3; c++) begin
					if (dv_rem_s[j-1][c] >= dsr) begin
						dv_rem_s[j][c] <= dv_rem_s[j-1][c] - dsr;
						dv_q_s[j][c]   <= dv_q_s[j-1][c] | (QW'(1) << K);
					end else begin
						dv_rem_s[j][c] <= dv_rem_s[j-1][c];
						dv_q_s[j][c]   <= dv_q_s[j-1][c];
					end
				end
				dv_len_s[j] <= dv_len_s[j-1];
				dv_tag_s[j] <= dv_tag_s[j-1];
			end
		end
	end

	// sign and zero
	logic [TW-1:0] tag_fin;
	assign tag_fin = dv_tag_s[QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= dv_v_s[QW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				if (tag_fin[0]) unit[c] <= '0;
				else if (tag_fin[c+1]) unit[c] <= UW'(-UW'(dv_q_s[QW][c]));
				else unit[c] <= UW'(dv_q_s[QW][c]);
			end
			zero     <= tag_fin[0];
			side_out <= tag_fin[TW-1:4];
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/lacb_cross.sv
// Two-stage cross product of unit vectors: products, then differences.
`default_nettype none
module lacb_cross #(
	parameter int UW = lacb_pkg::UNIT_FRAC_BITS + 2,
	parameter int SW = 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic [2:0][UW-1:0] a,
	input  wire logic [2:0][UW-1:0] b,
	input  wire logic [SW-1:0]      side_in,
	output logic                    out_valid,
	output logic [2:0][2*UW-1:0]    prod,
	output logic [SW-1:0]           side_out
);
	localparam int PW = 2 * UW;

	logic                          v_s1;
	logic signed [5:0][PW-1:0]     p_s1;
	logic [SW-1:0]                 side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= PW'($signed(a[1])) * PW'($signed(b[2]));
			p_s1[1] <= PW'($signed(a[2])) * PW'($signed(b[1]));
			p_s1[2] <= PW'($signed(a[2])) * PW'($signed(b[0]));
			p_s1[3] <= PW'($signed(a[0])) * PW'($signed(b[2]));
			p_s1[4] <= PW'($signed(a[0])) * PW'($signed(b[1]));
			p_s1[5] <= PW'($signed(a[1])) * PW'($signed(b[0]));
			side_s1 <= side_in;
			prod[0]  <= p_s1[0] - p_s1[1];
			prod[1]  <= p_s1[2] - p_s1[3];
			prod[2]  <= p_s1[4] - p_s1[5];
			side_out <= side_s1;
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/look_at_camera_basis_top.sv
// Top level of the look-at camera basis pipeline.
// The pipeline chains normalizers (forward and up in parallel, then right, then up axis, each
// a bitwise square root and one-bit-per-stage division) with two cross units between them.
// Throughput: one transaction per cycle; the whole pipeline holds while the output stalls.
// Reset: arst_n asynchronously clears all valid bits; data registers are not reset.
`default_nettype none
`include "look_at_camera_basis_top_macros.svh"
module look_at_camera_basis_top #(
	parameter int UNIT_FRAC_BITS = lacb_pkg::UNIT_FRAC_BITS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
	input  wire logic [287:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// right_x, right_y, right_z, upaxis_x, upaxis_y, upaxis_z, forward_x, forward_y, forward_z
	output logic [143:0]      m_tdata,
	// degenerate
	output logic              m_tuser
);
	localparam int CW = lacb_pkg::COORD_W;
	localparam int OW = lacb_pkg::UNIT_OUT_W;
	localparam int UW = UNIT_FRAC_BITS + 2;
	localparam int XW = 2 * UW;
	localparam int DW = CW + 1;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic [2:0][DW-1:0] dir;
	logic [2:0][CW-1:0] upv;
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			dir[c] = DW'($signed(s_tdata[(c+3)*CW +: CW])) - DW'($signed(s_tdata[c*CW +: CW]));
			upv[c] = s_tdata[(c+6)*CW +: CW];
		end
	end

	logic               fwd_v, up_v, fwd_z, up_z, fwd_sd, up_sd;
	logic [2:0][UW-1:0] fwd_u, up_u;

	lacb_norm #(.VW(DW), .UFB(UNIT_FRAC_BITS), .SW(1)) u_norm_fwd (
		.clk, .arst_n, .en, .in_valid(s_tvalid), .vec(dir), .side_in(1'b0),
		.out_valid(fwd_v), .unit(fwd_u), .zero(fwd_z), .side_out(fwd_sd)
	);

	lacb_norm #(.VW(CW), .UFB(UNIT_FRAC_BITS), .SW(1)) u_norm_up (
		.clk, .arst_n, .en, .in_valid(s_tvalid), .vec(upv), .side_in(1'b0),
		.out_valid(up_v), .unit(up_u), .zero(up_z), .side_out(up_sd)
	);

	localparam int S1 = 3 * UW + 1;
	logic               c1_v;
	logic [2:0][XW-1:0] c1_p;
	logic [S1-1:0]      c1_sd;

	lacb_cross #(.UW(UW), .SW(S1)) u_cross_right (
		.clk, .arst_n, .en, .in_valid(fwd_v), .a(up_u), .b(fwd_u),
		.side_in({fwd_u, fwd_z | up_z | fwd_sd | up_sd}),
		.out_valid(c1_v), .prod(c1_p), .side_out(c1_sd)
	);

	logic               rt_v, rt_z;
	logic [2:0][UW-1:0] rt_u;
	logic [S1-1:0]      rt_sd;

	lacb_norm #(.VW(XW), .UFB(UNIT_FRAC_BITS), .SW(S1)) u_norm_right (
		.clk, .arst_n, .en, .in_valid(c1_v), .vec(c1_p), .side_in(c1_sd),
		.out_valid(rt_v), .unit(rt_u), .zero(rt_z), .side_out(rt_sd)
	);

	localparam int S2 = 6 * UW + 1;
	logic               c2_v;
	logic [2:0][XW-1:0] c2_p;
	logic [S2-1:0]      c2_sd;
	logic [2:0][UW-1:0] fwd_d;
	assign fwd_d = rt_sd[S1-1:1];

	lacb_cross #(.UW(UW), .SW(S2)) u_cross_up (
		.clk, .arst_n, .en, .in_valid(rt_v), .a(fwd_d), .b(rt_u),
		.side_in({rt_u, fwd_d, rt_sd[0] | rt_z}),
		.out_valid(c2_v), .prod(c2_p), .side_out(c2_sd)
	);

	logic               ua_z;
	logic [2:0][UW-1:0] ua_u;
	logic [S2-1:0]      ua_sd;
	logic [2:0][UW-1:0] right_o, fwd_o;

	lacb_norm #(.VW(XW), .UFB(UNIT_FRAC_BITS), .SW(S2)) u_norm_upax (
		.clk, .arst_n, .en, .in_valid(c2_v), .vec(c2_p), .side_in(c2_sd),
		.out_valid(m_tvalid), .unit(ua_u), .zero(ua_z), .side_out(ua_sd)
	);

	assign right_o = ua_sd[S2-1 -: 3*UW];
	assign fwd_o   = ua_sd[3*UW:1];
	assign m_tuser = ua_sd[0] | ua_z;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			m_tdata[c*OW +: OW]     = OW'($signed(right_o[c]));
			m_tdata[(c+3)*OW +: OW] = OW'($signed(ua_u[c]));
			m_tdata[(c+6)*OW +: OW] = OW'($signed(fwd_o[c]));
		end
	end

	`LACB_ASSERT(a_norm_lockstep, fwd_v == up_v)
	`LACB_ASSERT(a_zero_fwd_degen, (m_tvalid && fwd_o == '0) |-> m_tuser)
	`LACB_ASSERT(a_zero_right_upax, (m_tvalid && right_o == '0) |-> (ua_u == '0))
endmodule
`default_nettype wire

// File: tb/sv/look_at_camera_basis_top_tb.sv
// Self-checking testbench for the look-at camera basis pipeline.
`default_nettype none
module look_at_camera_basis_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int UFB = lacb_pkg::UNIT_FRAC_BITS;
	localparam int LATENCY = 3 * (39 + UFB) + 4;
	localparam int WATCHDOG = 20 * LATENCY + 5000;
	localparam int N_RANDOM = 530;

	typedef struct packed {
		logic signed [31:0] ux, uy, uz, tx, ty, tz, ex, ey, ez;
	} cam_in_t;

	typedef struct {
		logic signed [15:0] ax[9];
		logic degen;
	} basis_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [287:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [143:0] m_tdata;
	logic m_tuser;

	look_at_camera_basis_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	basis_t expected_bases[$];
	int n_sent = 0, n_got = 0, n_bad = 0, n_degen = 0, idle_cycles = 0;
	int src_idle = 17, snk_idle = 47;
	bit hold_sink = 1'b0;
	bit stim_done = 1'b0;

	function automatic longint unsigned isqrt(longint unsigned s);
		longint unsigned root = 0, b = 64'd1 << 62;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= root + b) begin
				s -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	// returns 1 on zero length
	function automatic bit make_unit(input longint v[3], output longint u[3]);
		longint unsigned m[3], mx, s, len, q;
		int nb;
		mx = 0; s = 0; nb = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = v[i] < 0 ? -v[i] : v[i];
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) begin
			u = '{0, 0, 0};
			return 1'b1;
		end
		while (mx != 0) begin
			nb++;
			mx >>= 1;
		end
		for (int i = 0; i < 3; i++) begin
			m[i] = nb < 30 ? m[i] << (30 - nb) : m[i] >> (nb - 30);
			s += m[i] * m[i];
		end
		len = isqrt(s);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << UFB) + (len >> 1)) / len;
			u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1'b0;
	endfunction

	function automatic void cross_prod(input longint a[3], input longint b[3],
		output longint c[3]);
		c[0] = a[1] * b[2] - a[2] * b[1];
		c[1] = a[2] * b[0] - a[0] * b[2];
		c[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic basis_t look_at_basis(cam_in_t c);
		longint dir[3], up[3], fwd[3], upn[3], tmp[3], rgt[3], upax[3];
		basis_t r;
		dir = '{longint'(c.tx) - c.ex, longint'(c.ty) - c.ey, longint'(c.tz) - c.ez};
		up = '{longint'(c.ux), longint'(c.uy), longint'(c.uz)};
		r.degen = make_unit(dir, fwd);
		r.degen |= make_unit(up, upn);
		cross_prod(upn, fwd, tmp);
		r.degen |= make_unit(tmp, rgt);
		cross_prod(fwd, rgt, tmp);
		r.degen |= make_unit(tmp, upax);
		for (int i = 0; i < 3; i++) begin
			r.ax[i] = rgt[i][15:0];
			r.ax[3 + i] = upax[i][15:0];
			r.ax[6 + i] = fwd[i][15:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'(int'($urandom_range(0, 2000)) - 1000);
			2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			3: return 32'(int'($urandom_range(0, 8)) - 4);
			default: return 32'(int'($urandom_range(0, 32'h00ff_ffff)) - 32'h0080_0000);
		endcase
	endfunction

	function automatic cam_in_t rnd_cam();
		cam_in_t c;
		c = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
			rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
		case ($urandom_range(0, 19))
			0: {c.tx, c.ty, c.tz} = {c.ex, c.ey, c.ez};
			1: {c.ux, c.uy, c.uz} = '0;
			2: {c.ux, c.uy, c.uz} = {c.tx - c.ex, c.ty - c.ey, c.tz - c.ez};
			default: ;
		endcase
		return c;
	endfunction

	// directed rows; known results carry an explicit expectation
	typedef struct {
		cam_in_t c;
		bit known;
		logic [143:0] res;
		logic degen;
	} dir_row_t;
	localparam logic [31:0] MX = 32'h7fff_ffff, MN = 32'h8000_0000, ONE = 32'h0001_0000;
	localparam logic [15:0] U1 = 16'd16384, UM1 = -16'sd16384;
	dir_row_t dir_rows[$];

	initial begin
		dir_row_t r;
		r = '{c: '0, known: 1, res: '0, degen: 1};
		dir_rows.push_back(r);
		// look down -z with y up: right=-x, up=+y, forward=-z
		r.c = '{ux: 0, uy: ONE, uz: 0, tx: 0, ty: 0, tz: -ONE, ex: 0, ey: 0, ez: 0};
		r.res = {UM1, 16'd0, 16'd0, 16'd0, U1, 16'd0, 16'd0, 16'd0, UM1};
		r.degen = 0;
		r.known = 1;
		dir_rows.push_back(r);
		r.c = '{ux: 0, uy: 0, uz: 0, tx: 5, ty: 0, tz: 0, ex: 0, ey: 0, ez: 0};
		r.known = 0;
		dir_rows.push_back(r);
		r.c = '{ux: 0, uy: MX, uz: 0, tx: MX, ty: 0, tz: 0, ex: MN, ey: 0, ez: 0};
		dir_rows.push_back(r);
		r.c = '{ux: MN, uy: MN, uz: MN, tx: MN, ty: MN, tz: MN, ex: MX, ey: MX, ez: MX};
		dir_rows.push_back(r);
		r.c = '{ux: MX, uy: MN, uz: 1, tx: MX, ty: MX, tz: MX, ex: MN, ey: MN, ez: MN};
		dir_rows.push_back(r);
		r.c = '{ux: 1, uy: 0, uz: 0, tx: 0, ty: 0, tz: 1, ex: 0, ey: 0, ez: 0};
		dir_rows.push_back(r);
		r.c = '{ux: -1, uy: -1, uz: -1, tx: 1, ty: 1, tz: 1, ex: 0, ey: 0, ez: 0};
		dir_rows.push_back(r);
		r.c = '{ux: 0, uy: 1, uz: 0, tx: 3, ty: -4, tz: 12, ex: 0, ey: 0, ez: 0};
		dir_rows.push_back(r);
		r.c = '{ux: MX, uy: MX, uz: MX, tx: -1, ty: -1, tz: -1, ex: 0, ey: 0, ez: 0};
		dir_rows.push_back(r);
		r.c = '{ux: 32'h5555_5555, uy: 32'haaaa_aaaa, uz: 7, tx: 32'haaaa_aaaa,
			ty: 32'h5555_5555, tz: 0, ex: 32'h5555_5555, ey: 32'haaaa_aaaa, ez: 9};
		dir_rows.push_back(r);
		r.c = '{ux: 0, uy: 0, uz: 1, tx: 1, ty: 1, tz: 0, ex: 0, ey: 0, ez: 0};
		dir_rows.push_back(r);
	end

	task automatic send(cam_in_t c, bit known, logic [143:0] res, logic degen);
		basis_t b;
		b = look_at_basis(c);
		if (known) begin
			for (int i = 0; i < 9; i++) b.ax[i] = res[16 * i +: 16];
			b.degen = degen;
		end
		while ($urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {c.uz, c.uy, c.ux, c.tz, c.ty, c.tx, c.ez, c.ey, c.ex};
		do @(posedge clk); while (!s_tready);
		expected_bases.push_back(b);
		n_sent++;
	endtask

	always @(posedge clk) begin
		if (arst_n) m_tready <= !hold_sink && ($urandom_range(0, 99) >= snk_idle);
	end

	// long output stall, timed in cycles
	initial begin
		wait (n_sent >= 40);
		@(posedge clk);
		hold_sink <= 1'b1;
		repeat (2 * LATENCY) @(posedge clk);
		hold_sink <= 1'b0;
	end

	always @(posedge clk) begin
		basis_t b;
		if (arst_n && (s_tvalid && s_tready || m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (m_tvalid && m_tready) begin
			n_got++;
			if (expected_bases.size() == 0) begin
				n_bad++;
				if (n_bad <= 10) $display("unexpected transaction %h %b", m_tdata, m_tuser);
			end else begin
				b = expected_bases.pop_front();
				if (m_tuser) n_degen++;
				for (int i = 0; i <= 9; i++) begin
					if (i < 9 ? m_tdata[16 * i +: 16] !== b.ax[i] : m_tuser !== b.degen) begin
						n_bad++;
						if (n_bad <= 10)
							$display("mismatch out %0d field %0d: expected %h got %h", n_got,
								i, i < 9 ? b.ax[i] : 16'(b.degen),
								i < 9 ? m_tdata[16 * i +: 16] : 16'(m_tuser));
					end
				end
			end
		end
	end

	initial begin
		wait (idle_cycles >= WATCHDOG);
		$display("timeout after %0d idle cycles", idle_cycles);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) send(dir_rows[i].c, dir_rows[i].known, dir_rows[i].res,
			dir_rows[i].degen);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) begin
				src_idle = 47;
				snk_idle = 17;
			end
			if (i == 2 * N_RANDOM / 3) begin
				src_idle = 0;
				snk_idle = 0;
			end
			send(rnd_cam(), 0, '0, 0);
		end
		s_tvalid <= 1'b0;
		wait (expected_bases.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		$display("%0d camera inputs sent, %0d bases checked, %0d flagged degenerate",
			n_sent, n_got, n_degen);
		$display("covered extremes, zero-length forward/up/right, and a long output stall");
		if (n_bad == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", n_bad);
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
`default_nettype wire
